### rtl/bpfa_pkg.sv
// Shared types, constants and codes for the bitmap page frame allocator.
// Used by every module of the block; depends on nothing.
package bpfa_pkg;

  // Map geometry: one bit per page, 32 pages per memory word.
  localparam int MAX_PAGES = 32768;
  localparam int WORD_W    = 32;
  localparam int MAP_WORDS = MAX_PAGES / WORD_W;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int PAGE_W    = 15;
  localparam int CNT_W     = 16;
  localparam int NW_W      = ADDR_W + 1;

  // Operation codes carried in the input transaction.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Configuration register index.
  localparam logic REG_PAGE_COUNT = 1'b0;

  // Page limit information derived from the page count register.
  typedef struct packed {
    logic [CNT_W-1:0] limit;   // min(page_count, MAX_PAGES)
    logic [CNT_W-1:0] limit8;  // limit rounded up to whole map bytes
    logic [NW_W-1:0]  nwords;  // number of map words that hold those bytes
  } lim_t;

endpackage

### rtl/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator, top level. One request is in flight at a time. An in-range
// free or reserve reads its map word and writes it back in a read-modify-write step; out of
// range, no-op and an allocate with no map word left to read go straight to the result. An
// allocate reads 32-page map words in turn from the lowest word that may hold a free page.
// The next request is taken once the result has entered the output register, which waits
// while a previous result is not yet taken. After rst_n all 1024 map words are swept to
// all used, with in_tready low; free count resets to zero, page_count to 32768.
// Depends on bpfa_pkg.
module bitmap_page_frame_allocator_unit import bpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] page_index, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] granted_page, [30:15] free_count, [31] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lim_t              lim;
  logic [PAGE_W-1:0] granted;
  logic [CNT_W-1:0]  count;

  bpfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .lim     (lim)
  );

  bpfa_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .lim        (lim),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_page    (in_tdata[PAGE_W-1:0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_page   (granted),
    .out_count  (count)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {1'b0, count, granted};

endmodule

### rtl/bpfa_cfg.sv
// Configuration register block with an APB-style write/read port.
// Holds page_count and derives the page limit; depends on bpfa_pkg.
module bpfa_cfg import bpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lim_t        lim
);

  logic [CNT_W-1:0] page_count_r;
  logic [CNT_W-1:0] round_up;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);

  // Register write on the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= CNT_W'(MAX_PAGES);
    end else if (wr_en) begin
      page_count_r <= pwdata[CNT_W-1:0];
    end
  end

  // Read back the register; addresses with paddr[2] set read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAGE_COUNT) begin
      prdata = {{(32-CNT_W){1'b0}}, page_count_r};
    end
  end

  // Saturate the limit at the map size and round it up to whole map bytes.
  always_comb begin
    lim.limit  = (page_count_r > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_r;
    round_up   = lim.limit + CNT_W'(7);
    lim.limit8 = {round_up[CNT_W-1:3], 3'b000};
    lim.nwords = NW_W'((({1'b0, lim.limit8} + 17'd31) >> BIT_W));
  end

endmodule

### rtl/bpfa_find.sv
// Lowest-free-bit finder for one map word, masking bits past the managed bytes.
// Pure combinational logic; depends on bpfa_pkg.
module bpfa_find import bpfa_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  logic [ADDR_W-1:0] addr,
  input  lim_t              lim,
  output logic              found,
  output logic [BIT_W-1:0]  pos
);

  logic [NW_W-1:0]   addr_x;
  logic [NW_W-1:0]   lw;
  logic [BIT_W-1:0]  lb;
  logic [WORD_W-1:0] masked;

  assign addr_x = {1'b0, addr};
  assign lw     = lim.limit8[CNT_W-1:BIT_W];
  assign lb     = lim.limit8[BIT_W-1:0];

  // Bits of bytes at or past the managed limit count as used.
  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      masked[k] = word[k] || (addr_x > lw) ||
                  ((addr_x == lw) && ({1'b0, BIT_W'(k)} >= {1'b0, lb}));
    end
  end

  // Priority encoder: the lowest zero bit wins.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (!masked[k]) begin
        found = 1'b1;
        pos   = BIT_W'(k);
      end
    end
  end

endmodule

### rtl/bpfa_core.sv
// Allocator core: used-map memory, clearing pass, scan and read-modify-write FSM.
// Depends on bpfa_pkg and bpfa_find.
module bpfa_core import bpfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lim_t              lim,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [PAGE_W-1:0] in_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [PAGE_W-1:0] out_page,
  output logic [CNT_W-1:0]  out_count
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Used map: one bit per page, 1 = used.
  logic [WORD_W-1:0] mem [MAP_WORDS];

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [PAGE_W-1:0] pg_r, pg_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] hint_r, hint_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic [WORD_W-1:0] rdata_r;
  logic              re, we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [WORD_W-1:0] wdata;

  logic              found;
  logic [BIT_W-1:0]  pos;
  logic [PAGE_W-1:0] cand;
  logic [NW_W-1:0]   next_word;
  logic              page_bit;
  logic [WORD_W-1:0] pg_mask;
  logic [WORD_W-1:0] pos_mask;

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  bpfa_find u_find (
    .word  (rdata_r),
    .addr  (addr_r),
    .lim   (lim),
    .found (found),
    .pos   (pos)
  );

  assign cand      = {addr_r, pos};
  assign next_word = {1'b0, addr_r} + NW_W'(1);
  assign page_bit  = rdata_r[pg_r[BIT_W-1:0]];
  assign pg_mask   = WORD_W'(1) << pg_r[BIT_W-1:0];
  assign pos_mask  = WORD_W'(1) << pos;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_page   = out_page_r;
  assign out_count  = out_count_r;

  // Control: clearing pass, request decode, word scan and write-back.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    pg_nxt         = pg_r;
    addr_nxt       = addr_r;
    hint_nxt       = hint_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_count_nxt  = out_count_r;
    re             = 1'b0;
    raddr          = addr_r;
    we             = 1'b0;
    waddr          = addr_r;
    wdata          = rdata_r;

    // The output register empties when the consumer takes the transaction.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_op;
          pg_nxt         = in_page;
          res_status_nxt = ST_DONE;
          res_page_nxt   = '0;
          unique case (in_op)
            OP_ALLOC: begin
              if ({1'b0, hint_r} >= lim.nwords) begin
                res_status_nxt = ST_NOFREE;
                state_nxt      = S_DONE;
              end else begin
                re        = 1'b1;
                raddr     = hint_r;
                addr_nxt  = hint_r;
                state_nxt = S_SCAN;
              end
            end
            OP_FREE, OP_RESERVE: begin
              if ({1'b0, in_page} >= lim.limit) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                re        = 1'b1;
                raddr     = in_page[PAGE_W-1:BIT_W];
                addr_nxt  = in_page[PAGE_W-1:BIT_W];
                state_nxt = S_RMW;
              end
            end
            OP_NOP: begin
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RMW: begin
        if (op_r == OP_FREE) begin
          if (page_bit) begin
            we    = 1'b1;
            wdata = rdata_r & ~pg_mask;
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            if (addr_r < hint_r) begin
              hint_nxt = addr_r;
            end
          end
        end else begin
          if (!page_bit) begin
            we    = 1'b1;
            wdata = rdata_r | pg_mask;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        if (found) begin
          // Words below this one are full, so it stays the scan start.
          hint_nxt  = addr_r;
          state_nxt = S_DONE;
          if ({1'b0, cand} < lim.limit) begin
            we           = 1'b1;
            wdata        = rdata_r | pos_mask;
            res_page_nxt = cand;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end else begin
            res_status_nxt = ST_NOFREE;
          end
        end else if (next_word >= lim.nwords) begin
          hint_nxt       = addr_r;
          res_status_nxt = ST_NOFREE;
          state_nxt      = S_DONE;
        end else begin
          re       = 1'b1;
          raddr    = next_word[ADDR_W-1:0];
          addr_nxt = next_word[ADDR_W-1:0];
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          out_count_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      hint_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pg_r         <= pg_nxt;
    addr_r       <= addr_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

### verif/tb_bitmap_page_frame_allocator_unit.sv
// Self-checking testbench for bitmap_page_frame_allocator_unit: directed table, then random
// phases at several page counts, checked against an in-bench allocator predictor.
// Depends on bpfa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_unit;
  import bpfa_pkg::*;

  localparam int DIR_N          = 27;
  localparam int PH_N           = 6;
  localparam int HOLD_PHASE     = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [2:0] PAGE_COUNT_ADDR = {REG_PAGE_COUNT, 2'b00};

  // One allocator result as it appears on the result stream.
  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted;
    logic [CNT_W-1:0]  count;
  } grant_rec_t;

  // One directed row: either a page_count write or a request, with an
  // optional hand-typed result.
  typedef struct packed {
    logic              cfg_row;
    logic [CNT_W-1:0]  cfg_val;
    logic [1:0]        op;
    logic [PAGE_W-1:0] pg;
    logic              typed;
    grant_rec_t        want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [14:0] page_index, [15] zero
  logic [1:0]  in_tuser;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [14:0] granted_page, [30:15] free_count, [31] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state: one busy bit per page, the free tally and page_count.
  bit [MAX_PAGES-1:0] page_busy = '1;
  logic [CNT_W-1:0]   free_tally = '0;
  int unsigned        page_count_shadow = 32768;

  grant_rec_t  expected_grants [$];
  bit          failed = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles = 0;

  // Random phases: page count, request count, idling and share of allocations.
  int unsigned ph_pages     [PH_N] = '{64, 1, 300, 32768, 1000, 8};
  int unsigned ph_items     [PH_N] = '{300, 100, 350, 200, 450, 200};
  int unsigned ph_send_idle [PH_N] = '{20, 20, 81, 81, 0, 0};
  int unsigned ph_recv_idle [PH_N] = '{81, 81, 20, 20, 0, 0};
  int unsigned ph_alloc_pct [PH_N] = '{40, 40, 40, 5, 35, 40};

  // Directed rows. Hand-typed results cover the start from reset, page zero,
  // freeing a free page, reserving a used page and the no-op opcode.
  dir_row_t dir_tab [DIR_N] = '{
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b1, '{ST_NOFREE, 15'd0, 16'd0}},
    '{1'b0, 16'd0,     OP_FREE,    15'd0,     1'b1, '{ST_DONE,   15'd0, 16'd1}},
    '{1'b0, 16'd0,     OP_FREE,    15'd32767, 1'b1, '{ST_DONE,   15'd0, 16'd2}},
    '{1'b0, 16'd0,     OP_FREE,    15'd0,     1'b1, '{ST_DONE,   15'd0, 16'd2}},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b1, '{ST_DONE,   15'd0, 16'd1}},
    '{1'b0, 16'd0,     OP_RESERVE, 15'd32767, 1'b1, '{ST_DONE,   15'd0, 16'd0}},
    '{1'b0, 16'd0,     OP_RESERVE, 15'd32767, 1'b1, '{ST_DONE,   15'd0, 16'd0}},
    '{1'b0, 16'd0,     OP_NOP,     15'd32767, 1'b1, '{ST_DONE,   15'd0, 16'd0}},
    '{1'b0, 16'd0,     OP_FREE,    15'd100,   1'b0, '0},
    '{1'b0, 16'd0,     OP_FREE,    15'd3,     1'b0, '0},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_FREE,    15'd36,    1'b0, '0},
    '{1'b0, 16'd0,     OP_FREE,    15'd40,    1'b0, '0},
    '{1'b1, 16'd37,    OP_NOP,     15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_FREE,    15'd37,    1'b0, '0},
    '{1'b0, 16'd0,     OP_RESERVE, 15'd32767, 1'b0, '0},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b0, '0},
    '{1'b1, 16'd0,     OP_NOP,     15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_FREE,    15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b0, '0},
    '{1'b1, 16'd65535, OP_NOP,     15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_RESERVE, 15'd40,    1'b0, '0},
    '{1'b0, 16'd0,     OP_FREE,    15'd32767, 1'b0, '0},
    '{1'b0, 16'd0,     OP_ALLOC,   15'd0,     1'b0, '0},
    '{1'b0, 16'd0,     OP_NOP,     15'd0,     1'b0, '0}
  };

  bitmap_page_frame_allocator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one request to the predicted map and returns the result it gives.
  // The lowest free page below the limit is the one a first-fit map-word scan finds.
  function automatic grant_rec_t compute_alloc_result(input logic [1:0] op,
                                                      input logic [PAGE_W-1:0] pg);
    grant_rec_t  r;
    int unsigned lim;
    bit          found;
    r     = '{ST_DONE, '0, '0};
    lim   = (page_count_shadow < MAX_PAGES) ? page_count_shadow : MAX_PAGES;
    found = 1'b0;
    case (op)
      OP_ALLOC: begin
        r.status = ST_NOFREE;
        for (int p = 0; p < lim && !found; p++) begin
          if (!page_busy[p]) begin
            page_busy[p] = 1'b1;
            if (free_tally != '0) free_tally = free_tally - 1'b1;
            r.granted = p[PAGE_W-1:0];
            r.status  = ST_DONE;
            found     = 1'b1;
          end
        end
      end
      OP_FREE, OP_RESERVE: begin
        if (pg >= lim) begin
          r.status = ST_RANGE;
        end else if (op == OP_FREE) begin
          if (page_busy[pg]) begin
            page_busy[pg] = 1'b0;
            if (free_tally != '1) free_tally = free_tally + 1'b1;
          end
        end else if (!page_busy[pg]) begin
          page_busy[pg] = 1'b1;
          if (free_tally != '0) free_tally = free_tally - 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = free_tally;
    return r;
  endfunction

  // Offers one request after random idle cycles and records its expected result
  // once the transaction is accepted. Valid stays high on return.
  task automatic send_request(input logic [1:0] op, input logic [PAGE_W-1:0] pg,
                              input logic typed, input grant_rec_t want);
    grant_rec_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, pg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = compute_alloc_result(op, pg);
    expected_grants.push_back(typed ? want : pred);
  endtask

  // Lowers valid and waits until every outstanding result has been taken.
  task automatic drain_requests();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
  endtask

  // Writes page_count on the idle block and reads it back.
  task automatic program_page_count(input logic [CNT_W-1:0] value);
    drain_requests();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= PAGE_COUNT_ADDR;
    cfg_pwdata  <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    page_count_shadow = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {16'd0, value}) begin
      $display("%0t: page_count readback mismatch, expected %0d, got %0d",
               $time, value, cfg_prdata);
      failed = 1'b1;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result receiver: random backpressure, plus one long hold-off on request.
  initial begin : result_sink
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compares each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    grant_rec_t want;
    grant_rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[14:0], out_tdata[30:15]};
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result, got status %0d page %0d free %0d",
                 $time, got.status, got.granted, got.count);
        failed = 1'b1;
      end else begin
        want = expected_grants.pop_front();
        if (got.status !== want.status || got.granted !== want.granted ||
            got.count !== want.count) begin
          $display("%0t: mismatch, expected status %0d page %0d free %0d, got %0d %0d %0d",
                   $time, want.status, want.granted, want.count,
                   got.status, got.granted, got.count);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Main stimulus: reset, directed table, then the random phases.
  initial begin : stimulus
    logic [1:0]        op;
    logic [PAGE_W-1:0] pg;
    int unsigned       roll;
    int unsigned       lim;
    int unsigned       hi;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_NOP;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = PAGE_COUNT_ADDR;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run without idling.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_row) begin
        program_page_count(dir_tab[i].cfg_val);
      end else begin
        send_request(dir_tab[i].op, dir_tab[i].pg, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases. Most pages fall below or just past the managed limit so that
    // frees, reserves and allocations collide; the rest are anywhere.
    for (int ph = 0; ph < PH_N; ph++) begin
      program_page_count(ph_pages[ph][CNT_W-1:0]);
      sender_idle_pct = ph_send_idle[ph];
      recv_idle_pct   = ph_recv_idle[ph];
      lim = (ph_pages[ph] < MAX_PAGES) ? ph_pages[ph] : MAX_PAGES;
      hi  = (lim + 3 > 32767) ? 32767 : lim + 3;
      for (int i = 0; i < ph_items[ph]; i++) begin
        // Halfway through, hold back until the block has answered everything.
        if (i == ph_items[ph] / 2) drain_requests();
        if (ph == HOLD_PHASE && i == 10) hold_off_req = 1'b1;
        roll = $urandom_range(99);
        if (roll < ph_alloc_pct[ph]) op = OP_ALLOC;
        else if (roll < ph_alloc_pct[ph] + (95 - ph_alloc_pct[ph]) * 2 / 3) op = OP_FREE;
        else if (roll < 95) op = OP_RESERVE;
        else op = OP_NOP;
        if ($urandom_range(99) < 85) pg = PAGE_W'($urandom_range(hi, 0));
        else pg = PAGE_W'($urandom_range(32767, 0));
        send_request(op, pg, 1'b0, '0);
      end
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failed) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule

### bitmap_page_frame_allocator_unit.f
rtl/bpfa_pkg.sv
rtl/bpfa_cfg.sv
rtl/bpfa_find.sv
rtl/bpfa_core.sv
rtl/bitmap_page_frame_allocator_unit.sv
verif/tb_bitmap_page_frame_allocator_unit.sv
